// ----- hw/rtl/ktt_pkg.sv -----
// Package for the keyed timer table: sizes, request and result codes.
// Used by keyed_timer_table_top; depends on nothing else.
package ktt_pkg;
  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W = 16;
  localparam int unsigned IVL_W = 31;
  localparam int unsigned TIME_W = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [2:0] REQ_TICK = 3'd0;
  localparam logic [2:0] REQ_SET_TO = 3'd1;
  localparam logic [2:0] REQ_SET_IV = 3'd2;
  localparam logic [2:0] REQ_UPS_TO = 3'd3;
  localparam logic [2:0] REQ_UPS_IV = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;
  localparam logic [2:0] REQ_CLR_ALL = 3'd6;
  localparam logic [2:0] REQ_PAUSE = 3'd7;

  localparam logic [2:0] KIND_DONE = 3'd0;
  localparam logic [2:0] KIND_FIRED = 3'd1;
  localparam logic [2:0] KIND_ASSIGN = 3'd2;
  localparam logic [2:0] KIND_FULL = 3'd3;
  localparam logic [2:0] KIND_NOKEY = 3'd4;

  // Saturating due time: now plus a delay, clamped to the largest time.
  function automatic logic [TIME_W-1:0] due_after(input logic [TIME_W-1:0] now,
                                                  input logic [IVL_W-1:0] d);
    logic [TIME_W:0] t;
    t = {1'b0, now} + {{(TIME_W+1-IVL_W){1'b0}}, d};
    return t[TIME_W] ? TIME_MAX : t[TIME_W-1:0];
  endfunction
endpackage

// ----- hw/rtl/keyed_timer_table_top.sv -----
// Keyed timer table top level: slot memory, scan sequencer and result register.
// Depends on ktt_pkg.
//
//  channel | direction | tdata (low bit first)              | tuser | tlast
//  in_     | slave     | req_type[2:0] key[18:3] intv[49:19] | -     | -
//  out_    | master    | kind[2:0] result_key[18:3]          | -     | last
//
// Each slot is visited by a read state and then a compare state (S_RD, S_CHK), so ticks
// and key lookups scan the occupied slots, a clear that hits also shifts the later slots
// down, and a set or clear-all needs no scan. Each result waits in the output
// register and the scan stalls until it is taken. No clearing pass follows reset; rst_n
// is synchronous and active low, and the input is not ready while a word is busy.
module keyed_timer_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // req_type, key, interval, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // kind, result_key, zero pad
  output logic        out_tlast
);
  import ktt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SHR  = 3'd3;
  localparam logic [2:0] S_SHW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] due;
    logic [IVL_W-1:0]  period;
    logic              rep;
    logic              armed;
  } slot_t;

  slot_t mem [ENTRIES];
  slot_t rd_r;

  logic [2:0]        state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IVL_W-1:0]  ivl_r, ivl_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [KEY_W-1:0]  auto_r, auto_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              hit_r, hit_nxt;
  logic [IDX_W-1:0]  hidx_r, hidx_nxt;
  logic              ov_r, ov_nxt;
  logic [2:0]        okind_r, okind_nxt;
  logic [KEY_W-1:0]  okey_r, okey_nxt;
  logic              olast_r, olast_nxt;

  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  slot_t             wdata;
  logic              re;
  logic              emit;
  logic [2:0]        e_kind;
  logic [KEY_W-1:0]  e_key;
  logic              e_last;
  logic              out_free;

  assign out_free   = !ov_r || out_tready;
  assign in_tready  = (state_r == S_IDLE) && out_free;
  assign out_tvalid = ov_r;
  assign out_tdata  = {5'd0, okey_r, okind_r};
  assign out_tlast  = olast_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r; key_nxt = key_r; ivl_nxt = ivl_r;
    now_nxt = now_r; auto_nxt = auto_r; cnt_nxt = cnt_r;
    pos_nxt = pos_r; hit_nxt = hit_r; hidx_nxt = hidx_r;
    we = 1'b0; waddr = '0; wdata = rd_r;
    re = 1'b0; raddr = pos_r[IDX_W-1:0];
    emit = 1'b0; e_kind = KIND_DONE; e_key = '0; e_last = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = in_tdata[2:0];
          key_nxt = in_tdata[18:3];
          ivl_nxt = in_tdata[49:19];
          hit_nxt = 1'b0;
          case (in_tdata[2:0])
            REQ_TICK: begin
              if (now_r != TIME_MAX) begin
                now_nxt = now_r + 1'b1;
              end
              pos_nxt = cnt_r;
              state_nxt = S_RD;
            end
            REQ_SET_TO, REQ_SET_IV: state_nxt = S_FIN;
            REQ_CLR_ALL: begin
              cnt_nxt = '0;
              emit = 1'b1;
            end
            REQ_CLEAR: begin
              pos_nxt = cnt_r;
              state_nxt = S_RD;
            end
            default: begin
              pos_nxt = '0;
              state_nxt = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        // Ticks and clears walk downwards, lookups for upsert and pause upwards.
        if ((req_r == REQ_TICK) || (req_r == REQ_CLEAR)) begin
          if (pos_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            re = 1'b1;
            raddr = IDX_W'(pos_r - 1'b1);
            pos_nxt = pos_r - 1'b1;
            state_nxt = S_CHK;
          end
        end else begin
          if (pos_r >= cnt_r) begin
            state_nxt = S_FIN;
          end else begin
            re = 1'b1;
            raddr = pos_r[IDX_W-1:0];
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (req_r == REQ_TICK) begin
          if (rd_r.armed && (now_r >= rd_r.due)) begin
            if (out_free) begin
              emit = 1'b1; e_kind = KIND_FIRED; e_key = rd_r.key; e_last = 1'b0;
              we = 1'b1; waddr = pos_r[IDX_W-1:0];
              if (rd_r.rep) begin
                wdata.due = due_after(now_r, rd_r.period);
              end else begin
                wdata.armed = 1'b0;
              end
              state_nxt = S_RD;
            end
          end else begin
            state_nxt = S_RD;
          end
        end else if (rd_r.key == key_r) begin
          hit_nxt = 1'b1;
          hidx_nxt = pos_r[IDX_W-1:0];
          state_nxt = (req_r == REQ_CLEAR) ? S_SHR : S_FIN;
        end else begin
          if (req_r != REQ_CLEAR) begin
            pos_nxt = pos_r + 1'b1;
          end
          state_nxt = S_RD;
        end
      end
      S_SHR: begin
        // Shift later slots down by one: read the next slot here, write it one place lower in S_SHW.
        if (CNT_W'(pos_r + 1'b1) >= cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          re = 1'b1;
          raddr = IDX_W'(pos_r + 1'b1);
          state_nxt = S_SHW;
        end
      end
      S_SHW: begin
        we = 1'b1; waddr = pos_r[IDX_W-1:0]; wdata = rd_r;
        pos_nxt = pos_r + 1'b1;
        state_nxt = S_SHR;
      end
      S_FIN: begin
        if (out_free) begin
          emit = 1'b1;
          state_nxt = S_IDLE;
          wdata.period = ivl_r;
          wdata.due = due_after(now_r, ivl_r);
          wdata.rep = (req_r == REQ_SET_IV) || (req_r == REQ_UPS_IV);
          wdata.armed = 1'b1;
          case (req_r)
            REQ_TICK: begin
              e_kind = KIND_DONE; e_key = '0;
            end
            REQ_SET_TO, REQ_SET_IV: begin
              e_key = auto_r;
              if (cnt_r >= CNT_W'(ENTRIES)) begin
                e_kind = KIND_FULL;
              end else begin
                e_kind = KIND_ASSIGN;
                we = 1'b1; waddr = cnt_r[IDX_W-1:0]; wdata.key = auto_r;
                cnt_nxt = cnt_r + 1'b1;
                auto_nxt = auto_r + 1'b1;
              end
            end
            REQ_UPS_TO, REQ_UPS_IV: begin
              e_key = key_r;
              wdata.key = key_r;
              if (hit_r) begin
                e_kind = KIND_ASSIGN;
                we = 1'b1; waddr = hidx_r;
              end else if (cnt_r >= CNT_W'(ENTRIES)) begin
                e_kind = KIND_FULL;
              end else begin
                e_kind = KIND_ASSIGN;
                we = 1'b1; waddr = cnt_r[IDX_W-1:0];
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            REQ_CLEAR: begin
              e_key = key_r;
              e_kind = hit_r ? KIND_DONE : KIND_NOKEY;
              if (hit_r) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            default: begin
              e_key = key_r;
              e_kind = hit_r ? KIND_DONE : KIND_NOKEY;
              if (hit_r) begin
                we = 1'b1; waddr = hidx_r; wdata = rd_r; wdata.armed = 1'b0;
              end
            end
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    ov_nxt = ov_r && !out_tready;
    okind_nxt = okind_r; okey_nxt = okey_r; olast_nxt = olast_r;
    if (emit) begin
      ov_nxt = 1'b1; okind_nxt = e_kind; okey_nxt = e_key; olast_nxt = e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      now_r   <= '0;
      auto_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      now_r   <= now_nxt;
      auto_r  <= auto_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; key_r <= key_nxt; ivl_r <= ivl_nxt;
    pos_r <= pos_nxt; hit_r <= hit_nxt; hidx_r <= hidx_nxt;
    okind_r <= okind_nxt; okey_r <= okey_nxt; olast_r <= olast_nxt;
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(ENTRIES)) else $error("entry count above table size");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_tready |=> ov_r && $stable(okey_r) && $stable(okind_r))
    else $error("pending result changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready) else $error("ready while busy");
  a_now: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> $stable(now_r)) else $error("time moved mid-request");
`endif
endmodule

// ----- tb/sv/tb.sv -----
// Testbench for keyed_timer_table_top: drives request words, predicts every
// result word with its own timer table and checks them in order.
// Depends on ktt_pkg and keyed_timer_table_top.
`timescale 1ns / 1ps

module tb;
  import ktt_pkg::*;

  typedef struct packed {
    logic [2:0]       kind;
    logic [KEY_W-1:0] rkey;
    logic             last;
  } result_t;

  // Timer table model plus the queue of results still owed by the block.
  class timer_scoreboard;
    logic [TIME_W-1:0] now;
    logic [KEY_W-1:0]  auto_key;
    int                count;
    logic [KEY_W-1:0]  skey[ENTRIES];
    logic [TIME_W-1:0] sdue[ENTRIES];
    logic [IVL_W-1:0]  sper[ENTRIES];
    bit                srep[ENTRIES];
    bit                sarm[ENTRIES];
    result_t           pending[$];
    int                errors;

    function new();
      now = '0;
      auto_key = '0;
      count = 0;
      errors = 0;
    endfunction

    function logic [TIME_W-1:0] later(logic [IVL_W-1:0] d);
      logic [TIME_W:0] t;
      t = {1'b0, now} + d;
      return t[TIME_W] ? TIME_MAX : t[TIME_W-1:0];
    endfunction

    function void put(logic [2:0] k, logic [KEY_W-1:0] key, logic l);
      result_t r;
      r.kind = k;
      r.rkey = key;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void fill(int i, logic [KEY_W-1:0] key, logic [IVL_W-1:0] d, bit rep);
      skey[i] = key;
      sper[i] = d;
      sdue[i] = later(d);
      srep[i] = rep;
      sarm[i] = 1'b1;
    endfunction

    function int lowest(logic [KEY_W-1:0] key);
      for (int i = 0; i < count; i++) if (skey[i] == key) return i;
      return -1;
    endfunction

    function void note_request(logic [2:0] req, logic [KEY_W-1:0] key,
                               logic [IVL_W-1:0] d);
      int idx;
      case (req)
        REQ_TICK: begin
          if (now != TIME_MAX) now = now + 1'b1;
          for (int i = count - 1; i >= 0; i--) begin
            if (sarm[i] && now >= sdue[i]) begin
              put(KIND_FIRED, skey[i], 1'b0);
              if (srep[i]) sdue[i] = later(sper[i]);
              else sarm[i] = 1'b0;
            end
          end
          put(KIND_DONE, '0, 1'b1);
        end
        REQ_SET_TO, REQ_SET_IV: begin
          if (count < ENTRIES) begin
            fill(count, auto_key, d, req == REQ_SET_IV);
            count++;
            put(KIND_ASSIGN, auto_key, 1'b1);
            auto_key = auto_key + 1'b1;
          end else begin
            put(KIND_FULL, auto_key, 1'b1);
          end
        end
        REQ_UPS_TO, REQ_UPS_IV: begin
          idx = lowest(key);
          if (idx >= 0) begin
            fill(idx, key, d, req == REQ_UPS_IV);
            put(KIND_ASSIGN, key, 1'b1);
          end else if (count < ENTRIES) begin
            fill(count, key, d, req == REQ_UPS_IV);
            count++;
            put(KIND_ASSIGN, key, 1'b1);
          end else begin
            put(KIND_FULL, key, 1'b1);
          end
        end
        REQ_CLEAR: begin
          idx = -1;
          for (int i = count - 1; i >= 0 && idx < 0; i--) if (skey[i] == key) idx = i;
          if (idx < 0) begin
            put(KIND_NOKEY, key, 1'b1);
          end else begin
            for (int i = idx; i + 1 < count; i++) begin
              skey[i] = skey[i+1];
              sdue[i] = sdue[i+1];
              sper[i] = sper[i+1];
              srep[i] = srep[i+1];
              sarm[i] = sarm[i+1];
            end
            count--;
            put(KIND_DONE, key, 1'b1);
          end
        end
        REQ_CLR_ALL: begin
          count = 0;
          put(KIND_DONE, '0, 1'b1);
        end
        default: begin
          idx = lowest(key);
          if (idx < 0) begin
            put(KIND_NOKEY, key, 1'b1);
          end else begin
            sarm[idx] = 1'b0;
            put(KIND_DONE, key, 1'b1);
          end
        end
      endcase
    endfunction

    function void check_result(logic [2:0] k, logic [KEY_W-1:0] key, logic l);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: kind %0d key %0d last %0d", k, key, l);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, k);
        errors++;
      end
      if (key !== e.rkey) begin
        $error("result_key: expected %0d, actual %0d", e.rkey, key);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  timer_scoreboard sb = new();
  longint cycles = 0;
  bit     stall_on = 1;

  keyed_timer_table_top dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stretches of steady readiness alternate with random stalls.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[2:0], out_tdata[18:3], out_tlast);
    if (cycles % 64 == 0) stall_on <= $urandom_range(0, 2) != 0;
    out_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  int burst_left = 0;

  // Valid stays high across a burst; it drops only where a gap follows.
  task automatic send(logic [2:0] req, logic [KEY_W-1:0] key, logic [IVL_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1;
    in_tdata <= {6'b0, d, key, req};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, key, d);
  endtask

  // Keys are mostly drawn from a small pool so lookups hit often.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 4) == 0) return KEY_W'($urandom_range(0, 65535));
    return sb.count > 0 && $urandom_range(0, 2) != 0 ?
           sb.skey[$urandom_range(0, sb.count - 1)] : KEY_W'($urandom_range(0, 20));
  endfunction

  function automatic logic [IVL_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0: return {IVL_W{1'b1}};
      1: return IVL_W'($urandom());
      2: return '0;
      default: return IVL_W'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int r;
    logic [2:0] req;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty table, full table, duplicates, extremes, every request.
    send(REQ_TICK, '0, '0);
    send(REQ_CLEAR, 16'hFFFF, '0);
    send(REQ_PAUSE, 16'h0000, '0);
    send(REQ_SET_TO, 16'hFFFF, 31'd0);
    send(REQ_SET_IV, '0, 31'd1);
    send(REQ_SET_IV, '0, {IVL_W{1'b1}});
    send(REQ_UPS_TO, 16'h0001, 31'd2);
    send(REQ_UPS_IV, 16'hFFFF, 31'd3);
    send(REQ_TICK, '0, '0);
    send(REQ_TICK, '0, '0);
    send(REQ_PAUSE, 16'h0001, '0);
    for (int i = 0; i < 12; i++) send(REQ_SET_IV, '0, 31'd1);
    send(REQ_UPS_TO, 16'h5555, 31'd1);
    send(REQ_SET_TO, '0, 31'd1);
    send(REQ_TICK, '0, '0);
    send(REQ_CLEAR, 16'h0001, '0);
    send(REQ_CLR_ALL, '0, '0);

    for (int n = 0; n < 320; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) req = REQ_TICK;
      else if (r < 50) req = REQ_SET_TO;
      else if (r < 62) req = REQ_SET_IV;
      else if (r < 70) req = REQ_UPS_TO;
      else if (r < 78) req = REQ_UPS_IV;
      else if (r < 88) req = REQ_CLEAR;
      else if (r < 91) req = REQ_CLR_ALL;
      else req = REQ_PAUSE;
      send(req, pick_key(), pick_interval());
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
